>>> hw/rtl/asob_pkg.sv
`default_nettype none
package asob_pkg;
   localparam int unsigned PixW = 32;
   localparam int unsigned ChW = 8;
   localparam int unsigned NW = 16;
   localparam int unsigned NumW = 25;
   localparam int unsigned QW = 9;
   localparam int unsigned DivSteps = 3;
   localparam logic [ChW-1:0] AlphaMax = 8'hFF;
   localparam logic [NW-1:0] Div255 = 16'd255;
   localparam logic [NW-1:0] RoundA = 16'd127;

   typedef struct packed {
      logic [PixW-1:0] dst_color;
      logic [PixW-1:0] src_color;
   } req_type;

   typedef struct packed {
      logic [PixW-1:0] blended_color;
   } rsp_type;

   // numerators, divisor and bypass for the divide stages
   typedef struct packed {
      logic [2:0][NumW-1:0] num;
      logic [NW-1:0] n;
      logic [ChW-1:0] alpha;
      logic bypass;
      logic [PixW-1:0] pass_color;
   } mix_type;

   typedef struct packed {
      logic [2:0][NumW-1:0] rem;
      logic [2:0][QW-1:0] quo;
      logic [NW-1:0] n;
      logic [ChW-1:0] alpha;
      logic bypass;
      logic [PixW-1:0] pass_color;
   } div_type;
endpackage
`default_nettype wire

>>> hw/rtl/asob_if.sv
`default_nettype none
interface asob_if #(parameter type payload_type = logic);
   logic valid;
   logic ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/asob_mix.sv
`default_nettype none
module asob_mix (
   input  wire logic clock,
   input  wire logic enable,
   input  asob_pkg::req_type req,
   output asob_pkg::mix_type mix
);
   logic [7:0] as_w, ad_w, inv_w;
   logic [15:0] wa_ff, wa_in, wd_ff, wd_in;
   asob_pkg::req_type req_ff;
   asob_pkg::mix_type mix_in;

   assign as_w = req.src_color[31:24];
   assign ad_w = req.dst_color[31:24];
   assign inv_w = asob_pkg::AlphaMax - as_w;
   assign wa_in = {8'd0, as_w} * asob_pkg::Div255;
   assign wd_in = {8'd0, ad_w} * {8'd0, inv_w};

   always_ff @(posedge clock) begin
      if (enable) begin
         req_ff <= req;
         wa_ff <= wa_in;
         wd_ff <= wd_in;
      end
   end

   always_comb begin
      logic [asob_pkg::NW:0] nr;
      logic [7:0] sa;
      mix_in.n = wa_ff + wd_ff;
      for (int c = 0; c < 3; c++) begin
         mix_in.num[c] = 25'(wa_ff) * 25'(req_ff.src_color[8*c +: 8])
                       + 25'(wd_ff) * 25'(req_ff.dst_color[8*c +: 8]);
      end
      // (n+127)/255 for n < 65536: approx by *257>>16 then correct
      nr = {1'b0, mix_in.n} + {1'b0, asob_pkg::RoundA};
      sa = 8'((32'(nr) * 32'd257) >> 16);
      if (nr - 17'(sa) * 17'd255 >= 17'd255) sa = sa + 8'd1;
      mix_in.alpha = sa;
      sa = req_ff.src_color[31:24];
      mix_in.bypass = (sa == 8'd0) || (sa == asob_pkg::AlphaMax);
      mix_in.pass_color = (sa == 8'd0) ? req_ff.dst_color : req_ff.src_color;
   end

   always_ff @(posedge clock) begin
      if (enable) mix <= mix_in;
   end
endmodule
`default_nettype wire

>>> hw/rtl/asob_div.sv
`default_nettype none
module asob_div #(parameter int unsigned Step = 0) (
   input  wire logic clock,
   input  wire logic enable,
   input  asob_pkg::div_type din,
   output asob_pkg::div_type dout
);
   // three quotient bits per stage, restoring
   asob_pkg::div_type d_in;
   always_comb begin
      logic [asob_pkg::NumW:0] t;
      d_in = din;
      for (int k = 0; k < 3; k++) begin
         int b;
         b = 8 - 3*Step - k;
         for (int c = 0; c < 3; c++) begin
            t = 26'(din.n) << b;
            if ({1'b0, d_in.rem[c]} >= t) begin
               d_in.rem[c] = d_in.rem[c] - asob_pkg::NumW'(t);
               d_in.quo[c][b] = 1'b1;
            end
         end
      end
   end
   always_ff @(posedge clock) begin
      if (enable) dout <= d_in;
   end
endmodule
`default_nettype wire

>>> hw/rtl/argb_source_over_blend_top.sv
`default_nettype none
// Source-over blend of two ARGB8888 pixels, one item per clock unless
// stalled. Stages: weight multiply, numerators, then three restoring
// divide stages of three quotient bits each. Stalls freeze all stages.
module argb_source_over_blend_top (
   input wire logic clock,
   input wire logic reset,
   asob_if.sink req_ch,
   asob_if.source rsp_ch
);
   localparam int unsigned Depth = 2 + asob_pkg::DivSteps;
   logic [Depth-1:0] vld_ff, vld_in;
   logic enable;
   asob_pkg::mix_type mix;
   asob_pkg::div_type d0;
   asob_pkg::div_type dd [asob_pkg::DivSteps+1];

   assign enable = !vld_ff[Depth-1] || rsp_ch.ready;
   assign req_ch.ready = enable;
   assign vld_in = {vld_ff[Depth-2:0], req_ch.valid};

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (enable) vld_ff <= vld_in;
   end

   asob_mix u_mix (.clock(clock), .enable(enable), .req(req_ch.data), .mix(mix));

   always_comb begin
      d0.n = mix.n;
      d0.alpha = mix.alpha;
      d0.bypass = mix.bypass;
      d0.pass_color = mix.pass_color;
      for (int c = 0; c < 3; c++) begin
         d0.rem[c] = mix.num[c] + asob_pkg::NumW'(mix.n >> 1);
         d0.quo[c] = '0;
      end
   end
   assign dd[0] = d0;

   for (genvar s = 0; s < asob_pkg::DivSteps; s++) begin : g_div
      asob_div #(.Step(s)) u_div (.clock(clock), .enable(enable), .din(dd[s]),
                                  .dout(dd[s+1]));
   end

   always_comb begin
      asob_pkg::div_type f;
      f = dd[asob_pkg::DivSteps];
      if (f.bypass) rsp_ch.data.blended_color = f.pass_color;
      else rsp_ch.data.blended_color = {f.alpha, f.quo[2][7:0], f.quo[1][7:0],
                                        f.quo[0][7:0]};
   end
   assign rsp_ch.valid = vld_ff[Depth-1];

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |=> rsp_ch.valid)
      else $error("item dropped under stall");
   a_adv: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> vld_ff[0])
      else $error("accepted item lost");
   a_rdy: assert property (@(posedge clock) disable iff (reset)
      !rsp_ch.valid |-> req_ch.ready)
      else $error("stall without full output");
endmodule
`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

   class blend_scoreboard;
      logic [31:0] pending[$];
      int errors;

      function logic [31:0] blend_pixel(logic [31:0] dst, logic [31:0] src);
         logic [31:0] as_v, ad, inv, n, a, num, ch, res;
         as_v = {24'd0, src[31:24]};
         if (as_v == 0) return dst;
         if (as_v == 255) return src;
         ad = {24'd0, dst[31:24]};
         inv = 255 - as_v;
         n = as_v * 255 + ad * inv;
         if (n == 0) return 32'd0;
         a = ((n + 127) / 255) & 32'hFF;
         res = a << 24;
         for (int i = 0; i < 3; i++) begin
            num = {24'd0, src[i*8 +: 8]} * as_v * 255 + {24'd0, dst[i*8 +: 8]} * ad * inv;
            ch = ((num + n / 2) / n) & 32'hFF;
            res = res | (ch << (i * 8));
         end
         return res;
      endfunction

      function void note_pixels(asob_pkg::req_type r);
         pending.push_back(blend_pixel(r.dst_color, r.src_color));
      endfunction

      function void check_pixel(asob_pkg::rsp_type r);
         logic [31:0] want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected item, actual %h", $time, r.blended_color);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (want !== r.blended_color) begin
            $display("%0t: blended_color expected %h actual %h", $time, want,
                     r.blended_color);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   always #5 clock = ~clock;

   asob_if #(.payload_type(asob_pkg::req_type)) req_ch ();
   asob_if #(.payload_type(asob_pkg::rsp_type)) rsp_ch ();

   argb_source_over_blend_top dut (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source)
   );

   blend_scoreboard sb = new();
   int send_idle = 0;
   int recv_stall = 0;
   bit hold_off = 0;
   asob_pkg::req_type stim[$];

   initial begin
      req_ch.valid = 0;
      req_ch.data = '0;
      rsp_ch.ready = 0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) sb.note_pixels(req_ch.data);
         if (rsp_ch.valid && rsp_ch.ready) sb.check_pixel(rsp_ch.data);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 0;
      end else if (hold_off) begin
         rsp_ch.ready <= 0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall);
      end
   end

   function automatic logic [31:0] rand_pixel();
      logic [31:0] p;
      int k;
      p = $urandom;
      k = $urandom_range(9);
      if (k == 0) p[31:24] = 8'h00;
      else if (k == 1) p[31:24] = 8'hFF;
      else if (k == 2) p[31:24] = 8'($urandom_range(3));
      else if (k == 3) p[31:24] = 8'hFF - 8'($urandom_range(3));
      return p;
   endfunction

   task automatic send_items();
      asob_pkg::req_type it;
      while (stim.size() > 0) begin
         if ($urandom_range(99) < send_idle) begin
            req_ch.valid <= 0;
            @(posedge clock);
         end else begin
            it = stim.pop_front();
            req_ch.valid <= 1;
            req_ch.data <= it;
            @(posedge clock);
            while (!req_ch.ready) @(posedge clock);
         end
      end
      req_ch.valid <= 0;
   endtask

   task automatic add_random(int count);
      asob_pkg::req_type it;
      repeat (count) begin
         it.dst_color = rand_pixel();
         it.src_color = rand_pixel();
         stim.push_back(it);
      end
   endtask

   task automatic drain();
      while (sb.pending.size() > 0) @(posedge clock);
   endtask

   task automatic add_pair(logic [31:0] d, logic [31:0] s);
      asob_pkg::req_type it;
      it.dst_color = d;
      it.src_color = s;
      stim.push_back(it);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      add_pair(32'h0000_0000, 32'h0000_0000);
      add_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_pair(32'h1234_5678, 32'h00AB_CDEF);
      add_pair(32'h1234_5678, 32'hFFAB_CDEF);
      add_pair(32'h0000_0000, 32'h01FF_FFFF);
      add_pair(32'h00FF_FFFF, 32'h0100_0000);
      add_pair(32'hFFFF_FFFF, 32'h0100_0000);
      add_pair(32'hFF00_0000, 32'hFEFF_FFFF);
      add_pair(32'h0000_0000, 32'hFEFF_FFFF);
      add_pair(32'hFFFF_FFFF, 32'h8000_0000);
      add_pair(32'h80FF_00FF, 32'h8000_FF00);
      add_pair(32'h0155_AA55, 32'h7FAA_55AA);
      add_pair(32'hFFFF_FFFF, 32'hFEFF_FFFF);
      add_pair(32'h00FF_FFFF, 32'hFE00_0000);
      send_items();
      drain();
      add_random(400);
      send_items();
      recv_stall = 0; send_idle = 73;
      add_random(300);
      send_items();
      drain();
      repeat (10) @(posedge clock);
      send_idle = 0; recv_stall = 73;
      add_random(300);
      send_items();
      send_idle = 22; recv_stall = 22;
      add_random(300);
      send_items();
      send_idle = 0; recv_stall = 0;
      fork
         begin
            hold_off = 1;
            repeat (60) @(posedge clock);
            hold_off = 0;
         end
         begin
            add_random(300);
            send_items();
         end
      join
      drain();
      repeat (20) @(posedge clock);
      if (sb.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Simulation FAILED");
      $finish;
   end
endmodule
`default_nettype wire
